FILE: design/pdtr_pkg.sv
// ----------------------------------------------------------------------------
// pdtr_pkg
// Shared types and constants of the page display text renderer: the job word
// passed from front to back, command codes and the 5x8 glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

package pdtr_pkg;

   localparam int GLYPH_WIDTH = 5;
   localparam int PAGE_W      = 3;
   localparam int ROW_W       = 7;
   localparam int STEP_W      = 4;
   localparam int GLYPH_COUNT = 95;

   localparam logic [7:0] CMD_COLUMN_ADDR = 8'h21;
   localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;
   localparam logic [7:0] START_COLUMN    = 8'h00;
   localparam logic [7:0] BLANK_COLUMN    = 8'h00;
   localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
   localparam logic [7:0] FIRST_CODE      = 8'h20;
   localparam logic [7:0] LAST_CODE       = 8'h7E;

   localparam logic OP_PRINT = 1'b0;
   localparam logic OP_HOME  = 1'b1;

   // Steps of one job; a cursor run uses 0..5, a glyph 6..11.
   localparam logic [STEP_W-1:0] STEP_COL_CMD   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_COL_START = 4'd1;
   localparam logic [STEP_W-1:0] STEP_COL_END   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_PAGE_CMD  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_PAGE_ADDR = 4'd4;
   localparam logic [STEP_W-1:0] STEP_PAGE_END  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_GLYPH     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_BLANK     = 4'd11;

   typedef struct packed {
      logic              cursor;
      logic              glyph;
      logic [PAGE_W-1:0] page;
      logic [ROW_W-1:0]  row;
   } pdtr_job_type;

   // Column 0 of each glyph sits in bits 39:32.
   localparam logic [39:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700,
      40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001c224100,
      40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
      40'h0000A06000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324959513E,
      40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h55AA55AA55, 40'h0041417F00, 40'h0402010204,
      40'h4040404040, 40'h0003050000, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
      40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'hFC24242418,
      40'h18242418FC, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
      40'h4464544C44, 40'h00107C8200, 40'h0000FF0000,
      40'h00827C1000, 40'h0006090906
   };

endpackage

`default_nettype wire

FILE: design/pdtr_front.sv
// ----------------------------------------------------------------------------
// pdtr_front
// Accepts request words, tracks page and column, and turns each request into
// a job word (cursor run and/or glyph) for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtr_front #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_operation,
   input  wire logic [7:0]            req_char_code,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output pdtr_pkg::pdtr_job_type     push_job
);

   localparam int CW = $clog2(COLUMNS + 1);

   logic [pdtr_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [pdtr_pkg::PAGE_W-1:0] page_next;
   logic [pdtr_pkg::PAGE_W:0]   page_inc;
   logic [CW:0]                 col_reach;
   logic                        wrap;
   logic                        printable;
   logic                        accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   assign page_inc  = {1'b0, page_ff} + (pdtr_pkg::PAGE_W + 1)'(1);
   assign page_next = (page_inc >= (pdtr_pkg::PAGE_W + 1)'(PAGES)) ?
                      '0 : page_inc[pdtr_pkg::PAGE_W-1:0];
   assign col_reach = {1'b0, col_ff} + (CW + 1)'(pdtr_pkg::GLYPH_WIDTH);
   assign wrap      = col_reach >= (CW + 1)'(COLUMNS);
   assign printable = (req_char_code >= pdtr_pkg::FIRST_CODE) &&
                      (req_char_code <= pdtr_pkg::LAST_CODE);

   always_comb begin
      push_job.cursor = 1'b0;
      push_job.glyph  = 1'b0;
      push_job.page   = page_ff;
      push_job.row    = printable ?
                        pdtr_pkg::ROW_W'(req_char_code - pdtr_pkg::FIRST_CODE) : '0;
      page_in = page_ff;
      col_in  = col_ff;
      if (req_operation == pdtr_pkg::OP_HOME) begin
         push_job.cursor = 1'b1;
         push_job.page   = '0;
         page_in         = '0;
         col_in          = '0;
      end else if (req_char_code == pdtr_pkg::NEWLINE_CODE) begin
         push_job.cursor = 1'b1;
         push_job.page   = page_next;
         page_in         = page_next;
         col_in          = '0;
      end else if (wrap) begin
         push_job.cursor = 1'b1;
         push_job.glyph  = 1'b1;
         push_job.page   = page_next;
         page_in         = page_next;
         col_in          = CW'(pdtr_pkg::GLYPH_WIDTH + 1);
      end else begin
         push_job.glyph  = 1'b1;
         col_in          = col_ff + CW'(pdtr_pkg::GLYPH_WIDTH + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
         col_ff  <= '0;
      end else if (accept) begin
         page_ff <= page_in;
         col_ff  <= col_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/pdtr_queue.sv
// ----------------------------------------------------------------------------
// pdtr_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire pdtr_pkg::pdtr_job_type push_job,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output pdtr_pkg::pdtr_job_type      pop_job
);

   pdtr_pkg::pdtr_job_type entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: design/pdtr_back.sv
// ----------------------------------------------------------------------------
// pdtr_back
// Steps through each job one byte per cycle while rsp_ready does not stall
// the registered response channel that it drives.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtr_back #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire pdtr_pkg::pdtr_job_type pop_job,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_is_command,
   output logic [7:0]                  rsp_byte_value,
   output logic                        rsp_last_of_run
);

   logic [pdtr_pkg::STEP_W-1:0] step_ff, step_in;
   logic [pdtr_pkg::STEP_W-1:0] phase;
   logic [pdtr_pkg::STEP_W-1:0] glyph_sel;
   logic [39:0]                 glyph_bits;
   logic                        valid_ff, valid_in;
   logic                        cmd_ff, cmd_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        out_free, fire, last;

   assign out_free = !valid_ff || rsp_ready;
   assign fire     = pop_valid && out_free;
   assign phase    = pop_job.cursor ? step_ff : step_ff + pdtr_pkg::STEP_GLYPH;
   assign last     = pop_job.glyph ? (phase == pdtr_pkg::STEP_BLANK) :
                                     (phase == pdtr_pkg::STEP_PAGE_END);
   assign pop_ready  = out_free && last;
   assign glyph_sel  = phase - pdtr_pkg::STEP_GLYPH;
   assign glyph_bits = pdtr_pkg::GLYPH_ROM[pop_job.row];

   always_comb begin
      case (phase)
         pdtr_pkg::STEP_COL_CMD:   byte_in = pdtr_pkg::CMD_COLUMN_ADDR;
         pdtr_pkg::STEP_COL_START: byte_in = pdtr_pkg::START_COLUMN;
         pdtr_pkg::STEP_COL_END:   byte_in = 8'(COLUMNS - 1);
         pdtr_pkg::STEP_PAGE_CMD:  byte_in = pdtr_pkg::CMD_PAGE_ADDR;
         pdtr_pkg::STEP_PAGE_ADDR: byte_in = 8'(pop_job.page);
         pdtr_pkg::STEP_PAGE_END:  byte_in = 8'(PAGES - 1);
         pdtr_pkg::STEP_BLANK:     byte_in = pdtr_pkg::BLANK_COLUMN;
         default: begin
            case (glyph_sel[2:0])
               3'd0:    byte_in = glyph_bits[39:32];
               3'd1:    byte_in = glyph_bits[31:24];
               3'd2:    byte_in = glyph_bits[23:16];
               3'd3:    byte_in = glyph_bits[15:8];
               default: byte_in = glyph_bits[7:0];
            endcase
         end
      endcase
   end

   always_comb begin
      cmd_in   = phase < pdtr_pkg::STEP_GLYPH;
      last_in  = last;
      valid_in = valid_ff;
      step_in  = step_ff;
      if (fire) begin
         valid_in = 1'b1;
         step_in  = last ? '0 : step_ff + pdtr_pkg::STEP_W'(1);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cmd_ff  <= cmd_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_is_command  = cmd_ff;
   assign rsp_byte_value  = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

FILE: design/page_display_text_renderer.sv
// ----------------------------------------------------------------------------
// page_display_text_renderer
// Turns character codes and home requests into command and data bytes for a
// page-addressed monochrome display with a 5x8 font.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per character (req_operation 0) or home request
//   (req_operation 1). rsp_* carries one byte per word: rsp_is_command marks
//   command bytes, rsp_last_of_run marks the final byte of a request.
//   A printable character gives 6 data bytes, preceded by a 6-byte cursor
//   run when the line is full; newline and home give the cursor run alone.
//   The first byte of a request passes the job queue, then the response
//   register. Bytes leave at one byte per cycle while rsp_ready stays high,
//   a rate set by the single response register.
//   A two-entry job queue lets requests be taken while bytes still drain.
//   When rsp_ready is low the response word holds; the queue fills and then
//   req_ready drops. Reset clears page, column, queue and response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module page_display_text_renderer #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_is_command,
   output logic [7:0]      rsp_byte_value,
   output logic            rsp_last_of_run
);

   pdtr_pkg::pdtr_job_type push_job, pop_job;
   logic push_valid, push_ready, pop_valid, pop_ready;

   pdtr_front #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operation(req_operation),
      .req_char_code(req_char_code),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_job     (push_job)
   );

   pdtr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_job  (push_job),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job)
   );

   pdtr_back #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_job        (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_command (rsp_is_command),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for page_display_text_renderer. A directed table covers home,
// newline, page wrap, the glyph table ends and unprintable codes; then random
// text runs, newlines, homes and noise follow. Every response byte is checked
// against the table row's bytes if given, else a local model of page, column
// and the 5x8 font, under bursty request traffic and response stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS     = 128;
   localparam int PAGES       = 8;
   localparam int LATENCY     = 16;
   localparam int RAND_WORDS  = 75;

   localparam int STALL_NONE     = 0;
   localparam int STALL_RANDOM   = 1;
   localparam int STALL_PERIODIC = 2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] value;
      logic       last;
   } disp_byte_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  code;
      logic        given;
      logic        cmd;
      logic [47:0] bytes;
   } dir_row_type;

   localparam logic [39:0] FONT_COLS [0:94] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700,
      40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001c224100,
      40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
      40'h0000A06000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324959513E,
      40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h55AA55AA55, 40'h0041417F00, 40'h0402010204,
      40'h4040404040, 40'h0003050000, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
      40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'hFC24242418,
      40'h18242418FC, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
      40'h4464544C44, 40'h00107C8200, 40'h0000FF0000,
      40'h00827C1000, 40'h0006090906
   };

   localparam int DIR_ROWS = 23;
   localparam dir_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      {pdtr_pkg::OP_HOME,  8'h00, 1'b1, 1'b1, 48'h21007F220007},
      {pdtr_pkg::OP_PRINT, 8'h20, 1'b1, 1'b0, 48'h000000000000},
      {pdtr_pkg::OP_PRINT, 8'h00, 1'b1, 1'b0, 48'h000000000000},
      {pdtr_pkg::OP_PRINT, 8'hFF, 1'b1, 1'b0, 48'h000000000000},
      {pdtr_pkg::OP_PRINT, 8'h7F, 1'b1, 1'b0, 48'h000000000000},
      {pdtr_pkg::OP_PRINT, 8'h1F, 1'b1, 1'b0, 48'h000000000000},
      {pdtr_pkg::OP_PRINT, 8'h80, 1'b1, 1'b0, 48'h000000000000},
      {pdtr_pkg::OP_PRINT, 8'h21, 1'b1, 1'b0, 48'h00002F000000},
      {pdtr_pkg::OP_PRINT, 8'h7E, 1'b1, 1'b0, 48'h000609090600},
      {pdtr_pkg::OP_PRINT, 8'h41, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h7A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b1, 1'b1, 48'h21007F220107},
      {pdtr_pkg::OP_HOME,  8'hFF, 1'b1, 1'b1, 48'h21007F220007},
      {pdtr_pkg::OP_HOME,  8'h0A, 1'b1, 1'b1, 48'h21007F220007},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b0, 1'b0, 48'h0},
      {pdtr_pkg::OP_PRINT, 8'h0A, 1'b1, 1'b1, 48'h21007F220007},
      {pdtr_pkg::OP_PRINT, 8'h5F, 1'b0, 1'b0, 48'h0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = 1'b0;
   logic [7:0] req_char_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_command;
   logic [7:0] rsp_byte_value;
   logic       rsp_last_of_run;

   logic [2:0]    page_now = 3'd0;
   int            col_now = 0;
   disp_byte_type pending_bytes [$];
   int            errors = 0;
   int            burst_left = 4;

   page_display_text_renderer #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_command (rsp_is_command),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #1 clock = ~clock;

   function automatic void put_cursor(ref disp_byte_type run [$]);
      run.push_back({1'b1, pdtr_pkg::CMD_COLUMN_ADDR, 1'b0});
      run.push_back({1'b1, 8'(col_now), 1'b0});
      run.push_back({1'b1, 8'(COLUMNS - 1), 1'b0});
      run.push_back({1'b1, pdtr_pkg::CMD_PAGE_ADDR, 1'b0});
      run.push_back({1'b1, 8'(page_now), 1'b0});
      run.push_back({1'b1, 8'(PAGES - 1), 1'b0});
   endfunction

   function automatic void advance_line(ref disp_byte_type run [$]);
      page_now = (int'(page_now) + 1 >= PAGES) ? 3'd0 : page_now + 3'd1;
      col_now = 0;
      put_cursor(run);
   endfunction

   function automatic void render_word(input logic op, input logic [7:0] code,
                                       ref disp_byte_type run [$]);
      int row;
      run = {};
      if (op == pdtr_pkg::OP_HOME) begin
         page_now = 3'd0;
         col_now = 0;
         put_cursor(run);
      end else if (code == pdtr_pkg::NEWLINE_CODE) begin
         advance_line(run);
      end else begin
         row = (code >= pdtr_pkg::FIRST_CODE && code <= pdtr_pkg::LAST_CODE) ?
               int'(code - pdtr_pkg::FIRST_CODE) : 0;
         if (col_now + pdtr_pkg::GLYPH_WIDTH >= COLUMNS) begin
            advance_line(run);
         end
         for (int k = 0; k < 5; k++) begin
            run.push_back({1'b0, FONT_COLS[row][39 - 8*k -: 8], 1'b0});
         end
         run.push_back({1'b0, pdtr_pkg::BLANK_COLUMN, 1'b0});
         col_now += 6;
      end
      run[run.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic send_word(input dir_row_type row);
      disp_byte_type run [$];
      int            gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_operation = row.op;
      req_char_code = row.code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      render_word(row.op, row.code, run);
      if (row.given) begin
         for (int i = 0; i < 6; i++) begin
            pending_bytes.push_back({row.cmd, row.bytes[47 - 8*i -: 8], i == 5});
         end
      end else begin
         foreach (run[i]) pending_bytes.push_back(run[i]);
      end
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 6);
      end
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      disp_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("unexpected byte", rsp_byte_value, 0);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_is_command !== want.cmd)
               report_mismatch("is_command", rsp_is_command, want.cmd);
            if (rsp_byte_value !== want.value)
               report_mismatch("byte_value", rsp_byte_value, want.value);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", rsp_last_of_run, want.last);
         end
      end
   end

   initial begin : rsp_stall
      int mode;
      int phase;
      phase = 0;
      forever begin
         mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
         repeat ($urandom_range(20, 80)) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:     rsp_ready = 1'b1;
               STALL_RANDOM:   rsp_ready = 1'($urandom_range(0, 1));
               default:        rsp_ready = (phase % 7) >= 3;
            endcase
            phase++;
         end
      end
   end

   initial begin
      #400000;
      $display("[page_display_text_renderer] ERROR");
      $finish;
   end

   initial begin : stimulus
      int          sent;
      int          pick;
      int          run_len;
      bit          paused;
      bit          first_run;
      dir_row_type row;
      sent = 0;
      paused = 1'b0;
      first_run = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_word(DIR_TABLE[i]);
      end
      drain_all();

      while (sent < RAND_WORDS) begin
         pick = $urandom_range(0, 9);
         row = '0;
         if (first_run || pick < 6) begin
            run_len = first_run ? 25 : $urandom_range(1, 30);
            if (run_len > RAND_WORDS - sent) run_len = RAND_WORDS - sent;
            first_run = 1'b0;
            repeat (run_len) begin
               row.op = pdtr_pkg::OP_PRINT;
               row.code = 8'($urandom_range(pdtr_pkg::FIRST_CODE, pdtr_pkg::LAST_CODE));
               send_word(row);
               sent++;
            end
         end else if (pick == 6) begin
            row.op = pdtr_pkg::OP_PRINT;
            row.code = pdtr_pkg::NEWLINE_CODE;
            send_word(row);
            sent++;
         end else if (pick == 7) begin
            row.op = pdtr_pkg::OP_HOME;
            row.code = 8'($urandom_range(0, 255));
            send_word(row);
            sent++;
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4)) begin
               row.op = pdtr_pkg::OP_PRINT;
               row.code = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                               : 8'($urandom_range(8'h7F, 8'hFF));
               send_word(row);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               row.op = 1'($urandom_range(0, 1));
               row.code = 8'($urandom_range(0, 255));
               send_word(row);
               sent++;
            end
         end
         if (!paused && sent >= RAND_WORDS / 2) begin
            paused = 1'b1;
            drain_all();
         end
      end

      drain_all();
      if (errors == 0 && pending_bytes.size() == 0) begin
         $display("[page_display_text_renderer] OK");
      end else begin
         $display("[page_display_text_renderer] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
design/pdtr_pkg.sv
design/pdtr_front.sv
design/pdtr_queue.sv
design/pdtr_back.sv
design/page_display_text_renderer.sv
test/tb_top.sv
